### src/fcpm_pkg.sv
// Shared types and constants for the flash copy-on-write page map.
package fcpm_pkg;

  // Slot entry as stored in the map memory
  typedef struct packed {
    logic [7:0]  owner;
    logic [15:0] life;
  } slot_ent_t;

  localparam logic [7:0]  FREE_OWNER = 8'hff;
  localparam logic [15:0] LIFE_RESET = 16'hffff;
  localparam slot_ent_t   SLOT_RESET = '{owner: FREE_OWNER, life: LIFE_RESET};
  localparam logic [31:0] GEN_RESET  = 32'hffff_ffff;

  // Command codes
  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_WRITE  = 1'b1;

  // Status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_BAD_PAGE = 2'd2;

  // Register map
  localparam int          CFG_AW         = 3;
  localparam logic [0:0]  REG_COUNTER_MODE = 1'b0;
  localparam logic        COUNTER_MODE_RESET = 1'b1;

  // Result of one pass over all slots
  typedef struct packed {
    logic        hit;
    logic [7:0]  hit_slot;
    logic [15:0] hit_life;
    logic        found;
    logic [7:0]  best_slot;
    logic [15:0] best_life;
  } scan_res_t;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_WR_NEW,
    S_WR_CUR,
    S_DONE
  } state_t;

  // Next generation value after one committed change
  function automatic logic [31:0] gen_step(input logic [31:0] gen, input logic mode,
                                           input logic page_zero);
    logic [31:0] g;
    g = gen;
    if (mode && !page_zero) begin
      g = (gen | 32'h0000_00ff) - 32'd256;
    end else begin
      g = gen - 32'd1;
    end
    return g;
  endfunction

  // Change counter as reported: inverted generation, shifted in mode 1
  function automatic logic [15:0] change_value(input logic [31:0] gen, input logic mode);
    logic [15:0] v;
    v = mode ? ~gen[23:8] : ~gen[15:0];
    return v;
  endfunction

endpackage

### src/fcpm_slot_mem.sv
// Slot map memory: owner and life per slot, one read and one write port.
module fcpm_slot_mem #(
  parameter int SLOTS = 64,
  parameter int IW    = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [IW-1:0]       rd_addr,
  output fcpm_pkg::slot_ent_t rd_data,
  input  logic                wr_en,
  input  logic [IW-1:0]       wr_addr,
  input  fcpm_pkg::slot_ent_t wr_data
);
  import fcpm_pkg::*;

  slot_ent_t        mem_r [SLOTS];
  slot_ent_t        rd_q_r;
  logic [SLOTS-1:0] vld_r;
  logic             rd_vld_r;

  // Storage array, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_q_r <= mem_r[rd_addr];
  end

  // Written-entry flags; an entry never written reads as erased and free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : SLOT_RESET;

endmodule

### src/fcpm_scan.sv
// Slot scanner: one read per cycle, finds the page's slot and the best free slot.
module fcpm_scan #(
  parameter int SLOTS = 64,
  parameter int IW    = 6
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [7:0]           page,
  output logic [IW-1:0]        rd_addr,
  input  fcpm_pkg::slot_ent_t  rd_data,
  output logic                 done,
  output fcpm_pkg::scan_res_t  res
);
  import fcpm_pkg::*;

  localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

  logic [IW-1:0] cnt_r;
  logic [IW-1:0] tag_r;
  logic          act_r;
  logic          pend_r;
  logic          done_r;
  logic [7:0]    page_r;
  scan_res_t     res_r;

  assign rd_addr = cnt_r;

  // Read issue and data-return tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r  <= 1'b0;
      pend_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= pend_r && !act_r;
      pend_r <= act_r;
      if (start) begin
        act_r <= 1'b1;
        cnt_r <= '0;
      end else if (act_r) begin
        if (cnt_r == LAST) begin
          act_r <= 1'b0;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (act_r) begin
      tag_r <= cnt_r;
    end
  end

  // Accumulate first match and largest nonzero free life (first on ties)
  always_ff @(posedge clk) begin
    if (start) begin
      page_r <= page;
      res_r  <= '0;
    end else if (pend_r) begin
      if (!res_r.hit && rd_data.owner == page_r) begin
        res_r.hit      <= 1'b1;
        res_r.hit_slot <= 8'(tag_r);
        res_r.hit_life <= rd_data.life;
      end
      if (rd_data.owner == FREE_OWNER && rd_data.life > res_r.best_life) begin
        res_r.found     <= 1'b1;
        res_r.best_slot <= 8'(tag_r);
        res_r.best_life <= rd_data.life;
      end
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

### src/flash_cow_page_map_core.sv
// Flash copy-on-write page map with wear leveling: top level.
// Each item is either a lookup or a write commit for one logical page. A valid-page
// lookup or a commit that changes contents scans the whole map: the slot memory has
// one read port and every item walks all SLOTS entries once, one entry per cycle, to
// find the page's slot and the free slot with the largest nonzero life; the write-back
// states S_WR_NEW and S_WR_CUR follow. An invalid page or an unchanged commit skips both.
// One item is in flight at a time; the result sits in an output register
// so the next item is taken while it waits. The map needs no clearing pass after
// reset: entries never written read as free with full life.
module flash_cow_page_map_core #(
  parameter int SLOTS = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_cmd,
  input  logic [7:0]                  in_logical_page,
  input  logic                        in_unchanged,
  input  logic                        in_in_place_ok,
  input  logic                        in_new_blank,
  // result channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [7:0]                  out_phys_slot,
  output logic                        out_slot_valid,
  output logic [7:0]                  out_erase_slot,
  output logic                        out_erase_valid,
  output logic [1:0]                  out_status,
  output logic [15:0]                 out_change_counter,
  // configuration port
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [fcpm_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);
  import fcpm_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  state_t      state_r, state_nxt;
  logic        mode_r;
  logic [31:0] gen_r;

  logic        cmd_r;
  logic [7:0]  page_r;
  logic        in_place_r;
  logic        blank_r;

  logic [7:0]  res_phys_r;
  logic        res_pv_r;
  logic [7:0]  res_erase_r;
  logic        res_ev_r;
  logic [1:0]  res_status_r;
  logic        wr_new_r;
  logic        wr_cur_r;

  logic        out_valid_r;
  logic [7:0]  out_phys_r;
  logic        out_pv_r;
  logic [7:0]  out_erase_r;
  logic        out_ev_r;
  logic [1:0]  out_status_r;
  logic [15:0] out_cc_r;

  logic        accept;
  logic        page_ok;
  logic        need_scan;
  logic        scan_done;
  logic        out_load;
  scan_res_t   sres;
  logic [IW-1:0] rd_addr;
  slot_ent_t   rd_data;
  logic        mem_we;
  logic [IW-1:0] mem_waddr;
  slot_ent_t   mem_wdata;
  logic        cfg_wr;
  logic        gen_step_en;

  // Configuration register
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= COUNTER_MODE_RESET;
    end else if (cfg_wr && cfg_paddr[CFG_AW-1:2] == REG_COUNTER_MODE) begin
      mode_r <= cfg_pwdata[0];
    end
  end

  assign cfg_prdata = (cfg_paddr[CFG_AW-1:2] == REG_COUNTER_MODE) ? {31'd0, mode_r} : 32'd0;

  // Input transfer decode
  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign page_ok   = in_logical_page < 8'(SLOTS);
  assign need_scan = page_ok && (in_cmd == CMD_LOOKUP || !in_unchanged);

  fcpm_slot_mem #(.SLOTS(SLOTS), .IW(IW)) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata)
  );

  fcpm_scan #(.SLOTS(SLOTS), .IW(IW)) u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (accept && need_scan),
    .page    (in_logical_page),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .done    (scan_done),
    .res     (sres)
  );

  // Write-back: new owner first, then free and wear the old slot
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = sres.best_slot[IW-1:0];
    mem_wdata = '{owner: page_r, life: sres.best_life};
    case (state_r)
      S_WR_NEW: begin
        mem_we = wr_new_r;
      end
      S_WR_CUR: begin
        mem_we    = wr_cur_r;
        mem_waddr = sres.hit_slot[IW-1:0];
        mem_wdata = '{owner: FREE_OWNER, life: sres.hit_life - 16'd1};
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Controller next state
  always_comb begin
    state_nxt = state_r;
    out_load  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = need_scan ? S_SCAN : S_DONE;
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          state_nxt = S_WR_NEW;
        end
      end
      S_WR_NEW: begin
        state_nxt = S_WR_CUR;
      end
      S_WR_CUR: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Commit decision once the scan is complete
  assign gen_step_en = (state_r == S_SCAN) && scan_done && (cmd_r == CMD_WRITE) &&
                       ((in_place_r && sres.hit) || blank_r || sres.found);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_r <= GEN_RESET;
    end else if (gen_step_en) begin
      gen_r <= gen_step(gen_r, mode_r, page_r == 8'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_new_r <= 1'b0;
      wr_cur_r <= 1'b0;
    end else if (accept) begin
      wr_new_r <= 1'b0;
      wr_cur_r <= 1'b0;
    end else if (state_r == S_SCAN && scan_done && cmd_r == CMD_WRITE &&
                 !(in_place_r && sres.hit) && (blank_r || sres.found)) begin
      wr_new_r <= !blank_r;
      wr_cur_r <= sres.hit;
    end
  end

  // Item latch and result fields
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r        <= in_cmd;
      page_r       <= in_logical_page;
      in_place_r   <= in_in_place_ok;
      blank_r      <= in_new_blank;
      res_phys_r   <= 8'd0;
      res_pv_r     <= 1'b0;
      res_erase_r  <= 8'd0;
      res_ev_r     <= 1'b0;
      res_status_r <= page_ok ? ST_OK : ST_BAD_PAGE;
    end else if (state_r == S_SCAN && scan_done) begin
      if (cmd_r == CMD_LOOKUP || (in_place_r && sres.hit)) begin
        res_phys_r <= sres.hit ? sres.hit_slot : 8'd0;
        res_pv_r   <= sres.hit;
      end else if (!blank_r && !sres.found) begin
        res_status_r <= ST_NO_SPACE;
      end else begin
        res_phys_r  <= blank_r ? 8'd0 : sres.best_slot;
        res_pv_r    <= !blank_r;
        res_erase_r <= sres.hit ? sres.hit_slot : 8'd0;
        res_ev_r    <= sres.hit;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_phys_r   <= res_phys_r;
      out_pv_r     <= res_pv_r;
      out_erase_r  <= res_erase_r;
      out_ev_r     <= res_ev_r;
      out_status_r <= res_status_r;
      out_cc_r     <= change_value(gen_r, mode_r);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_phys_slot      = out_phys_r;
  assign out_slot_valid     = out_pv_r;
  assign out_erase_slot     = out_erase_r;
  assign out_erase_valid    = out_ev_r;
  assign out_status         = out_status_r;
  assign out_change_counter = out_cc_r;

  // Checks
  a_scan_done_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    scan_done |-> state_r == S_SCAN)
    else $error("scan finished outside the scan state");

  a_write_only_in_wb: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_WR_NEW || state_r == S_WR_CUR))
    else $error("map write outside write-back");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result presented without completing an item");

  a_move_distinct: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_pv_r && out_ev_r) |-> out_phys_r != out_erase_r)
    else $error("new slot equals erased slot");

  a_fail_no_slots: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_OK) |-> (!out_pv_r && !out_ev_r))
    else $error("failed item reports a slot");

endmodule

### sim/tb_flash_cow_page_map_core.sv
// Testbench for the flash copy-on-write page map: predicted lookup and commit results.
`timescale 1ns / 100ps

module tb_flash_cow_page_map_core;
  import fcpm_pkg::*;

  localparam int SLOTS       = 64;
  localparam int CYCLE_LIMIT = 1_000_000;

  typedef struct packed {
    logic [7:0]  phys_slot;
    logic        slot_valid;
    logic [7:0]  erase_slot;
    logic        erase_valid;
    logic [1:0]  status;
    logic [15:0] change_counter;
  } slot_answer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_cmd = CMD_LOOKUP;
  logic [7:0]  in_logical_page = '0;
  logic        in_unchanged = 1'b0;
  logic        in_in_place_ok = 1'b0;
  logic        in_new_blank = 1'b0;

  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_phys_slot;
  logic        out_slot_valid;
  logic [7:0]  out_erase_slot;
  logic        out_erase_valid;
  logic [1:0]  out_status;
  logic [15:0] out_change_counter;

  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [31:0]       cfg_pwdata = '0;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  // Shadow of the page map
  logic [7:0]  owner_of [SLOTS];
  logic [15:0] life_of [SLOTS];
  logic [31:0] gen_ctr;
  logic        cnt_mode;

  slot_answer_t slot_answers[$];
  int errors = 0;
  int cycle_cnt = 0;
  int burst_left = 0;
  int rx_left = 0;
  int rx_regime = 0;

  flash_cow_page_map_core #(.SLOTS(SLOTS)) dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Run watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Receiver backpressure: regimes of random length (always ready, coin flip, mostly stalled)
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_regime = $urandom_range(0, 2);
      rx_left = $urandom_range(20, 200);
    end
    rx_left--;
    case (rx_regime)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Applies one lookup or commit to the shadow map and returns the result it gives
  function automatic slot_answer_t map_access(input logic cmd, input logic [7:0] page,
                                              input logic unch, input logic inpl,
                                              input logic blank);
    slot_answer_t a;
    int cur;
    int fresh;
    logic [15:0] best;
    logic stepped;
    a = '0;
    a.status = ST_OK;
    cur = SLOTS;
    fresh = SLOTS;
    best = '0;
    stepped = 1'b0;
    if (page >= SLOTS) begin
      a.status = ST_BAD_PAGE;
    end else begin
      for (int i = 0; i < SLOTS; i++)
        if (cur == SLOTS && owner_of[i] == page) cur = i;
      if (cmd == CMD_LOOKUP) begin
        if (cur < SLOTS) begin
          a.phys_slot = 8'(cur);
          a.slot_valid = 1'b1;
        end
      end else if (!unch) begin
        if (inpl && cur < SLOTS) begin
          // reprogram over the current slot
          a.phys_slot = 8'(cur);
          a.slot_valid = 1'b1;
          stepped = 1'b1;
        end else begin
          // wear leveling: free slot with the largest nonzero life, first on ties
          if (!blank)
            for (int i = 0; i < SLOTS; i++)
              if (owner_of[i] == FREE_OWNER && life_of[i] > best) begin
                best = life_of[i];
                fresh = i;
              end
          if (!blank && fresh == SLOTS) begin
            a.status = ST_NO_SPACE;
          end else begin
            if (fresh < SLOTS) begin
              owner_of[fresh] = page;
              a.phys_slot = 8'(fresh);
              a.slot_valid = 1'b1;
            end
            if (cur < SLOTS) begin
              owner_of[cur] = FREE_OWNER;
              life_of[cur] = life_of[cur] - 16'd1;
              a.erase_slot = 8'(cur);
              a.erase_valid = 1'b1;
            end
            stepped = 1'b1;
          end
        end
      end
    end
    if (stepped)
      gen_ctr = (cnt_mode && page != 8'd0) ? (gen_ctr | 32'h0000_00ff) - 32'd256
                                          : gen_ctr - 32'd1;
    a.change_counter = cnt_mode ? ~gen_ctr[23:8] : ~gen_ctr[15:0];
    return a;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // Result checker
  always @(posedge clk) begin : check_results
    slot_answer_t want;
    if (rst_n && out_valid && out_ready) begin
      if (slot_answers.size() == 0) begin
        $error("result transfer with no result pending");
        errors++;
      end else begin
        want = slot_answers.pop_front();
        check_field("phys_slot", 16'(want.phys_slot), 16'(out_phys_slot));
        check_field("slot_valid", 16'(want.slot_valid), 16'(out_slot_valid));
        check_field("erase_slot", 16'(want.erase_slot), 16'(out_erase_slot));
        check_field("erase_valid", 16'(want.erase_valid), 16'(out_erase_valid));
        check_field("status", 16'(want.status), 16'(out_status));
        check_field("change_counter", want.change_counter, out_change_counter);
      end
    end
  end

  // One input transfer; the sender may idle between bursts of random length
  task automatic send_access(input logic cmd, input logic [7:0] page, input logic unch,
                             input logic inpl, input logic blank);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_logical_page <= page;
    in_unchanged <= unch;
    in_in_place_ok <= inpl;
    in_new_blank <= blank;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    slot_answers.push_back(map_access(cmd, page, unch, inpl, blank));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (slot_answers.size() != 0) @(posedge clk);
  endtask

  // Register write then read back, only with the map idle
  task automatic set_counter_mode(input logic mode);
    wait_drained();
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= CFG_AW'(4 * int'(REG_COUNTER_MODE));
    cfg_pwdata <= 32'(mode);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cnt_mode = mode;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (cfg_prdata !== 32'(mode)) begin
      $error("counter_mode readback: expected %0d, got %0d", mode, cfg_prdata);
      errors++;
    end
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // Extremes of the fields and each commit path but no space, in both counter modes
  task automatic test_directed_cases();
    send_access(CMD_LOOKUP, 8'd0, 1'b0, 1'b0, 1'b0);    // miss on empty map
    send_access(CMD_LOOKUP, 8'd255, 1'b0, 1'b0, 1'b0);  // invalid page
    send_access(CMD_WRITE, 8'd64, 1'b1, 1'b1, 1'b1);    // first invalid page
    send_access(CMD_WRITE, 8'd0, 1'b0, 1'b0, 1'b0);     // allocate page 0
    send_access(CMD_WRITE, 8'd63, 1'b0, 1'b0, 1'b0);    // allocate last page
    send_access(CMD_LOOKUP, 8'd0, 1'b0, 1'b0, 1'b0);
    send_access(CMD_LOOKUP, 8'd63, 1'b0, 1'b0, 1'b0);
    send_access(CMD_WRITE, 8'd0, 1'b0, 1'b1, 1'b0);     // in place
    send_access(CMD_WRITE, 8'd5, 1'b0, 1'b1, 1'b0);     // in place on unallocated page
    send_access(CMD_WRITE, 8'd0, 1'b1, 1'b1, 1'b1);     // unchanged wins
    send_access(CMD_WRITE, 8'd63, 1'b0, 1'b0, 1'b1);    // blank frees its slot
    send_access(CMD_WRITE, 8'd63, 1'b0, 1'b0, 1'b1);    // blank with nothing to free
    send_access(CMD_WRITE, 8'd0, 1'b0, 1'b0, 1'b0);     // move, skip worn slot
    send_access(CMD_WRITE, 8'd5, 1'b0, 1'b0, 1'b0);
    send_access(CMD_LOOKUP, 8'd5, 1'b0, 1'b0, 1'b0);
    set_counter_mode(1'b0);
    send_access(CMD_WRITE, 8'd128, 1'b0, 1'b1, 1'b0);
    send_access(CMD_WRITE, 8'd0, 1'b0, 1'b1, 1'b0);
    send_access(CMD_WRITE, 8'd7, 1'b0, 1'b0, 1'b0);
    send_access(CMD_WRITE, 8'd7, 1'b0, 1'b1, 1'b1);     // in place beats blank
    send_access(CMD_LOOKUP, 8'd7, 1'b0, 1'b0, 1'b0);
    send_access(CMD_LOOKUP, 8'd170, 1'b1, 1'b1, 1'b1);
    send_access(CMD_WRITE, 8'd85, 1'b0, 1'b0, 1'b0);
  endtask

  // Fill every slot, then hit the no-space path and recover from it
  task automatic test_full_map();
    set_counter_mode(1'b1);
    for (int p = 0; p < SLOTS; p++)
      send_access(CMD_WRITE, 8'(p), 1'b0, 1'b0, 1'b0);
    send_access(CMD_WRITE, 8'd10, 1'b0, 1'b0, 1'b0);    // no space
    send_access(CMD_WRITE, 8'd0, 1'b0, 1'b0, 1'b0);     // no space, page 0
    send_access(CMD_WRITE, 8'd10, 1'b0, 1'b1, 1'b0);    // in place still works
    send_access(CMD_WRITE, 8'd10, 1'b0, 1'b0, 1'b1);
    send_access(CMD_WRITE, 8'd20, 1'b0, 1'b0, 1'b0);
    send_access(CMD_LOOKUP, 8'd20, 1'b0, 1'b0, 1'b0);
    send_access(CMD_WRITE, 8'd10, 1'b0, 1'b0, 1'b0);
    send_access(CMD_LOOKUP, 8'd10, 1'b0, 1'b0, 1'b0);
  endtask

  // Random lookups and commits; blank_pct sets how full the map stays
  task automatic test_random_traffic(input logic mode, input int blank_pct,
                                     input int count);
    logic [7:0] page;
    int pick;
    set_counter_mode(mode);
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) page = 8'($urandom_range(SLOTS, 255));
      else if (pick < 20) page = 8'd0;
      else page = 8'($urandom_range(0, SLOTS - 1));
      send_access(($urandom_range(0, 99) < 30) ? CMD_LOOKUP : CMD_WRITE, page,
                  $urandom_range(0, 99) < 10, $urandom_range(0, 99) < 40,
                  $urandom_range(0, 99) < blank_pct);
    end
  endtask

  initial begin
    foreach (owner_of[i]) begin
      owner_of[i] = FREE_OWNER;
      life_of[i] = LIFE_RESET;
    end
    gen_ctr = GEN_RESET;
    cnt_mode = COUNTER_MODE_RESET;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_full_map();
    test_random_traffic(1'b0, 10, 280);
    test_random_traffic(1'b1, 50, 280);
    test_random_traffic(1'b1, 25, 280);
    test_random_traffic(1'b0, 70, 280);
    test_random_traffic(1'b1, 20, 280);

    // drain, then watch for stray results
    wait_drained();
    repeat (2 * SLOTS) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
